// ===== rtl/cbd_pkg.sv =====
// Shared types and constants of the chunked body decoder.
// No dependencies; every other file refers to it by scoped names.
package cbd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LINE_W     = 17;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // Register map (word index taken from paddr[CSR_ADDR_W-1:2])
   localparam logic [CSR_ADDR_W-3:0] REG_MAX_LINE_LENGTH = '0;
   localparam logic [LINE_W-1:0]     MAX_LINE_RESET      = 17'd65536;

   // Framing characters
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_LONG_LINE = 2'd3
   } err_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              start_of_body;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] body_byte;
      logic              body_valid;
      logic              body_complete;
      err_type           error_code;
   } result_type;

endpackage

// ===== rtl/cbd_if.sv =====
// Valid/ready channel interfaces of the chunked body decoder.
// Depends on cbd_pkg for field widths.
interface cbd_req_if;
   logic                           valid;
   logic                           ready;
   logic [cbd_pkg::BYTE_W-1:0]     byte_in;
   logic                           start_of_body;

   modport source (output valid, output byte_in, output start_of_body, input ready);
   modport sink   (input valid, input byte_in, input start_of_body, output ready);
endinterface

interface cbd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cbd_pkg::BYTE_W-1:0]     body_byte;
   logic                           body_valid;
   logic                           body_complete;
   logic [1:0]                     error_code;

   modport source (output valid, output body_byte, output body_valid,
                   output body_complete, output error_code, input ready);
   modport sink   (input valid, input body_byte, input body_valid,
                   input body_complete, input error_code, output ready);
endinterface

// ===== rtl/chunked_body_decoder_core.sv =====
// Top level of the chunked body decoder: input register, framing engine,
// result register and APB configuration. Depends on cbd_pkg, cbd_if,
// cbd_csr and cbd_engine.
// Path: a byte passes the input register, then the engine's result register;
//   the input register holds its byte while a full result is not taken.
//   Throughput: one byte per cycle while the receiver takes results, as the
//   framing engine updates its state on every step.
// Reset: synchronous, active high; decoder restarts at a size line and
//   max_line_length returns to 65536.
module chunked_body_decoder_core #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   cbd_req_if.sink                            req_ch,
   cbd_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic                         in_valid_ff, in_valid_in;
   cbd_pkg::item_type            item_ff;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_free;
   logic                         advance;
   logic [cbd_pkg::LINE_W-1:0]   max_line;
   cbd_pkg::result_type          result;

   cbd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready),
      .max_line (max_line)
   );

   // Advance when the result register is empty or being drained
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.byte_in       <= req_ch.byte_in;
         item_ff.start_of_body <= req_ch.start_of_body;
      end
   end

   cbd_engine #(
      .SIZE_BITS (SIZE_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .item     (item_ff),
      .max_line (max_line),
      .result   (result)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.body_byte     = result.body_byte;
   assign rsp_ch.body_valid    = result.body_valid;
   assign rsp_ch.body_complete = result.body_complete;
   assign rsp_ch.error_code    = result.error_code;

endmodule

// ===== rtl/cbd_csr.sv =====
// APB-style configuration register block: holds max_line_length.
// Depends on cbd_pkg.
module cbd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cbd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cbd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cbd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [cbd_pkg::LINE_W-1:0]         max_line
);

   logic [cbd_pkg::LINE_W-1:0] max_line_ff;
   logic [cbd_pkg::LINE_W-1:0] max_line_in;
   logic                       hit;

   // Decode the word index, ignore byte offset
   assign hit    = (paddr[cbd_pkg::CSR_ADDR_W-1:2] == cbd_pkg::REG_MAX_LINE_LENGTH);
   assign pready = 1'b1;

   // Take the low bits of the write data on the access phase
   always_comb begin
      max_line_in = max_line_ff;
      if (psel && penable && pwrite && hit) begin
         max_line_in = pwdata[cbd_pkg::LINE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= cbd_pkg::MAX_LINE_RESET;
      end else begin
         max_line_ff <= max_line_in;
      end
   end

   // Return the register on a hit, zero elsewhere
   assign prdata   = hit ? cbd_pkg::CSR_DATA_W'(max_line_ff) : '0;
   assign max_line = max_line_ff;

endmodule

// ===== rtl/cbd_engine.sv =====
// Chunked framing state machine: one byte per step, result registered.
// Depends on cbd_pkg.
module cbd_engine #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  cbd_pkg::item_type            item,
   input  logic [cbd_pkg::LINE_W-1:0]   max_line,
   output cbd_pkg::result_type          result
);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_REST,
      PH_DATA,
      PH_TAIL,
      PH_TRAILER,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // Returns {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [cbd_pkg::BYTE_W-1:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   phase_type                    phase_ff, phase_in, cur_phase;
   logic [SIZE_BITS-1:0]         remain_ff, remain_in, cur_remain;
   logic [cbd_pkg::LINE_W-1:0]   len_ff, len_in, cur_len;
   logic                         cr_ff, cr_in, cur_cr;
   logic                         digits_ff, digits_in, cur_digits;
   logic                         empty_ff, empty_in, cur_empty;
   cbd_pkg::err_type             error_ff, error_in, cur_error;
   cbd_pkg::result_type          result_ff, result_in;

   logic [cbd_pkg::BYTE_W-1:0]   b;
   logic [4:0]                   hex;
   logic                         lf_end;
   logic                         too_long;
   logic                         is_blank;
   logic                         is_cr;

   assign b        = item.byte_in;
   assign hex      = hex_decode(b);
   assign is_blank = (b == cbd_pkg::CH_SP) || (b == cbd_pkg::CH_TAB);
   assign is_cr    = (b == cbd_pkg::CH_CR);

   // Start of body: work from the reset state
   always_comb begin
      if (item.start_of_body) begin
         cur_phase  = PH_LEAD;
         cur_remain = '0;
         cur_len    = '0;
         cur_cr     = 1'b0;
         cur_digits = 1'b0;
         cur_empty  = 1'b1;
         cur_error  = cbd_pkg::ERR_NONE;
      end else begin
         cur_phase  = phase_ff;
         cur_remain = remain_ff;
         cur_len    = len_ff;
         cur_cr     = cr_ff;
         cur_digits = digits_ff;
         cur_empty  = empty_ff;
         cur_error  = error_ff;
      end
   end

   assign lf_end   = (b == cbd_pkg::CH_LF) && cur_cr;
   assign too_long = (cur_len >= max_line);

   // Next state and result for one byte
   always_comb begin
      phase_in  = cur_phase;
      remain_in = cur_remain;
      len_in    = cur_len;
      cr_in     = cur_cr;
      digits_in = cur_digits;
      empty_in  = cur_empty;
      error_in  = cur_error;
      result_in = '0;

      unique case (cur_phase) inside
         PH_LEAD, PH_DIGITS, PH_REST: begin
            if (lf_end) begin
               if (!cur_digits) begin
                  error_in = cbd_pkg::ERR_MALFORMED;
                  phase_in = PH_ERROR;
               end else begin
                  // Close the size line; keep the size for the data phase
                  phase_in  = (cur_remain == '0) ? PH_TRAILER : PH_DATA;
                  len_in    = '0;
                  cr_in     = 1'b0;
                  digits_in = 1'b0;
                  empty_in  = 1'b1;
               end
            end else if (too_long) begin
               error_in = cbd_pkg::ERR_LONG_LINE;
               phase_in = PH_ERROR;
            end else begin
               len_in = cur_len + cbd_pkg::LINE_W'(1);
               cr_in  = is_cr;
               if ((cur_phase == PH_LEAD && !is_blank) || cur_phase == PH_DIGITS) begin
                  if (hex[4]) begin
                     // Shift in a digit unless the top nibble is already used
                     if (cur_remain[SIZE_BITS-1 -: 4] != 4'd0) begin
                        error_in = cbd_pkg::ERR_OVERFLOW;
                        phase_in = PH_ERROR;
                     end else begin
                        remain_in = {cur_remain[SIZE_BITS-5:0], hex[3:0]};
                        digits_in = 1'b1;
                        phase_in  = PH_DIGITS;
                     end
                  end else begin
                     phase_in = PH_REST;
                  end
               end
            end
         end
         PH_DATA: begin
            result_in.body_byte  = b;
            result_in.body_valid = 1'b1;
            if (cur_remain == SIZE_BITS'(1)) begin
               phase_in  = PH_TAIL;
               remain_in = SIZE_BITS'(2);
            end else begin
               remain_in = cur_remain - SIZE_BITS'(1);
            end
         end
         PH_TAIL: begin
            // Drop the two bytes after the payload unchecked
            if (cur_remain == SIZE_BITS'(1)) begin
               phase_in  = PH_LEAD;
               remain_in = '0;
               len_in    = '0;
               cr_in     = 1'b0;
               digits_in = 1'b0;
               empty_in  = 1'b1;
            end else begin
               remain_in = cur_remain - SIZE_BITS'(1);
            end
         end
         PH_TRAILER: begin
            if (lf_end) begin
               if (cur_empty) begin
                  result_in.body_complete = 1'b1;
                  phase_in = PH_DONE;
                  cr_in    = 1'b0;
               end else begin
                  remain_in = '0;
                  len_in    = '0;
                  cr_in     = 1'b0;
                  digits_in = 1'b0;
                  empty_in  = 1'b1;
               end
            end else if (too_long) begin
               error_in = cbd_pkg::ERR_LONG_LINE;
               phase_in = PH_ERROR;
            end else begin
               len_in   = cur_len + cbd_pkg::LINE_W'(1);
               empty_in = cur_empty && is_cr && !cur_cr;
               cr_in    = is_cr;
            end
         end
         default: begin
            // Done or error: hold
         end
      endcase

      result_in.error_code = error_in;
   end

   // Hold state and the result register; advance on a step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         remain_ff <= '0;
         len_ff    <= '0;
         cr_ff     <= 1'b0;
         digits_ff <= 1'b0;
         empty_ff  <= 1'b1;
         error_ff  <= cbd_pkg::ERR_NONE;
         result_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         len_ff    <= len_in;
         cr_ff     <= cr_in;
         digits_ff <= digits_in;
         empty_ff  <= empty_in;
         error_ff  <= error_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   // A payload byte always has a byte left to count
   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remain_ff != '0)
      else $error("data phase with zero bytes remaining");

   // An error is sticky until a new body starts
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.start_of_body && error_ff != cbd_pkg::ERR_NONE
      |=> error_ff == $past(error_ff))
      else $error("sticky error changed without restart");

   // An error state and an error code go together
   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) == (error_ff != cbd_pkg::ERR_NONE))
      else $error("error phase and error code disagree");

   // Completion leads to the done state
   a_complete_done: assert property (@(posedge clock) disable iff (reset)
      step_en && result_in.body_complete |=> phase_ff == PH_DONE)
      else $error("completion without done state");

endmodule

// ===== test/chunked_decode_checker.sv =====
// Scoreboard for the chunked body decoder: watches both channels and the APB
// port, predicts each result byte by byte and compares. Depends on cbd_pkg
// and the channel interfaces of cbd_if.
module chunked_decode_checker #(
   parameter int unsigned SIZE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   cbd_req_if                             req_mon,
   cbd_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding
);

   typedef enum logic [2:0] {
      ST_LEAD, ST_DIGITS, ST_REST, ST_DATA, ST_TAIL, ST_TRAILER, ST_DONE, ST_ERROR
   } frame_type;

   // Decoder state as predicted
   frame_type                  dec_phase;
   logic [SIZE_BITS-1:0]       remaining;
   logic [cbd_pkg::LINE_W-1:0] line_len;
   logic [cbd_pkg::LINE_W-1:0] max_len;
   logic                       cr_seen;
   logic                       have_digits;
   logic                       blank_line;
   cbd_pkg::err_type           sticky;

   cbd_pkg::result_type decoded_outputs[$];
   int unsigned         fail_count = 0;

   function automatic void raise(cbd_pkg::err_type code);
      sticky    = code;
      dec_phase = ST_ERROR;
   endfunction

   function automatic void open_line(frame_type next);
      dec_phase   = next;
      line_len    = '0;
      cr_seen     = 1'b0;
      have_digits = 1'b0;
      blank_line  = 1'b1;
      remaining   = '0;
   endfunction

   function automatic void restart_frame();
      open_line(ST_LEAD);
      sticky = cbd_pkg::ERR_NONE;
   endfunction

   // Count one line byte; raise the long-line error if it does not fit
   function automatic bit take_line_byte();
      if (line_len >= max_len) begin
         raise(cbd_pkg::ERR_LONG_LINE);
         return 1'b0;
      end
      line_len = line_len + cbd_pkg::LINE_W'(1);
      return 1'b1;
   endfunction

   function automatic int hex_nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   // Shift in one hex digit; overflow as soon as the top nibble is in use
   function automatic void push_digit(logic [3:0] nib);
      if (remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
         raise(cbd_pkg::ERR_OVERFLOW);
      end else begin
         remaining   = {remaining[SIZE_BITS-5:0], nib};
         have_digits = 1'b1;
      end
   endfunction

   function automatic cbd_pkg::result_type decode_step(logic [7:0] b, logic sob);
      cbd_pkg::result_type  r;
      logic                 lf_close;
      int                   nib;
      logic [SIZE_BITS-1:0] size_hold;
      r = '0;
      if (sob) restart_frame();
      lf_close = (b == cbd_pkg::CH_LF) && cr_seen;
      case (dec_phase)
         ST_LEAD, ST_DIGITS, ST_REST: begin
            if (lf_close) begin
               if (!have_digits) begin
                  raise(cbd_pkg::ERR_MALFORMED);
               end else if (remaining == '0) begin
                  open_line(ST_TRAILER);
               end else begin
                  size_hold = remaining;
                  open_line(ST_DATA);
                  remaining = size_hold;
               end
            end else if (take_line_byte()) begin
               cr_seen = (b == cbd_pkg::CH_CR);
               nib     = hex_nibble(b);
               if (dec_phase == ST_LEAD) begin
                  // blanks are skipped; anything else ends the lead-in
                  if (b != cbd_pkg::CH_SP && b != cbd_pkg::CH_TAB) begin
                     if (nib >= 0) begin
                        dec_phase = ST_DIGITS;
                        push_digit(nib[3:0]);
                     end else begin
                        dec_phase = ST_REST;
                     end
                  end
               end else if (dec_phase == ST_DIGITS) begin
                  if (nib >= 0) push_digit(nib[3:0]);
                  else dec_phase = ST_REST;
               end
            end
         end
         ST_DATA: begin
            r.body_byte  = b;
            r.body_valid = 1'b1;
            remaining    = remaining - SIZE_BITS'(1);
            if (remaining == '0) begin
               dec_phase = ST_TAIL;
               remaining = SIZE_BITS'(2);
            end
         end
         ST_TAIL: begin
            // drop the two bytes after the payload unchecked
            remaining = remaining - SIZE_BITS'(1);
            if (remaining == '0) open_line(ST_LEAD);
         end
         ST_TRAILER: begin
            if (lf_close) begin
               if (blank_line) begin
                  r.body_complete = 1'b1;
                  dec_phase       = ST_DONE;
                  cr_seen         = 1'b0;
               end else begin
                  open_line(ST_TRAILER);
               end
            end else if (take_line_byte()) begin
               blank_line = blank_line && (b == cbd_pkg::CH_CR) && !cr_seen;
               cr_seen    = (b == cbd_pkg::CH_CR);
            end
         end
         default: begin
         end
      endcase
      r.error_code = sticky;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      cbd_pkg::result_type got;
      cbd_pkg::result_type want;
      if (reset) begin
         max_len = cbd_pkg::MAX_LINE_RESET;
         restart_frame();
         decoded_outputs.delete();
      end else begin
         // compare each result transfer with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.body_byte     = rsp_mon.body_byte;
            got.body_valid    = rsp_mon.body_valid;
            got.body_complete = rsp_mon.body_complete;
            got.error_code    = cbd_pkg::err_type'(rsp_mon.error_code);
            if (decoded_outputs.size() == 0) begin
               $display("%0t: unexpected result: expected none, got %h", $time, got);
               fail_count++;
            end else begin
               want = decoded_outputs.pop_front();
               compare_field("body_byte", want.body_byte, got.body_byte);
               compare_field("body_valid", 8'(want.body_valid), 8'(got.body_valid));
               compare_field("body_complete", 8'(want.body_complete),
                             8'(got.body_complete));
               compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
            end
         end
         // predict each input transfer
         if (req_mon.valid && req_mon.ready)
            decoded_outputs.push_back(decode_step(req_mon.byte_in, req_mon.start_of_body));
         // follow register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[cbd_pkg::CSR_ADDR_W-1:2] == cbd_pkg::REG_MAX_LINE_LENGTH)
            max_len = csr_pwdata[cbd_pkg::LINE_W-1:0];
      end
      mismatches  <= fail_count;
      outstanding <= decoded_outputs.size();
   end

endmodule

// ===== test/testbench.sv =====
// Top of the chunked body decoder testbench: clock, reset, byte stream and
// register writes, with random idling on both channels. Depends on cbd_pkg,
// cbd_if, chunked_body_decoder_core and chunked_decode_checker.
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [cbd_pkg::CSR_ADDR_W-1:0]      csr_paddr;
   logic [cbd_pkg::CSR_DATA_W-1:0]      csr_pwdata;
   logic [cbd_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                csr_pready;

   int unsigned mismatches;
   int unsigned outstanding;

   // body under construction, and idling controls
   logic [7:0] body_q[$];
   bit         calm      = 1'b0;
   bit         long_hold = 1'b0;

   cbd_req_if req_bus();
   cbd_rsp_if rsp_bus();

   chunked_body_decoder_core #(.SIZE_BITS(32)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   chunked_decode_checker #(.SIZE_BITS(32)) decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly no gap, some short, a few long; none at all in calm stretches
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic put_byte(logic [7:0] b);
      body_q.push_back(b);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
   endtask

   task automatic put_crlf();
      body_q.push_back(cbd_pkg::CH_CR);
      body_q.push_back(cbd_pkg::CH_LF);
   endtask

   // Hex size in minimal form, each letter in random case
   task automatic put_hex(logic [31:0] v);
      string      s;
      logic [7:0] c;
      s = $sformatf("%0h", v);
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
         body_q.push_back(c);
      end
   endtask

   task automatic put_hex_digit();
      string digits;
      digits = "0123456789abcdefABCDEF";
      body_q.push_back(digits[$urandom_range(1, 21)]);
   endtask

   // Size line: mostly well formed, sometimes one of the broken forms
   task automatic put_size_line(logic [31:0] size);
      int unsigned variant;
      variant = $urandom_range(0, 19);
      repeat ($urandom_range(0, 2))
         put_byte($urandom_range(0, 1) ? cbd_pkg::CH_SP : cbd_pkg::CH_TAB);
      case (variant)
         0: begin
            put_text($urandom_range(0, 1) ? "+" : "-");
            put_hex(size);
         end
         1: begin
            put_text("0x");
            put_hex(size);
         end
         2: begin
            if ($urandom_range(0, 1) == 1) put_text(";ext");
         end
         3: begin
            repeat ($urandom_range(9, 11)) put_hex_digit();
         end
         4: begin
            put_hex(size);
            put_text(";a");
            put_byte($urandom_range(0, 1) ? cbd_pkg::CH_CR : cbd_pkg::CH_LF);
            put_text("b");
         end
         5: begin
            put_text("FFFFffff");
         end
         default: begin
            repeat ($urandom_range(0, 3)) put_text("0");
            put_hex(size);
            if ($urandom_range(0, 3) == 0) put_text(";name=val");
         end
      endcase
      put_crlf();
   endtask

   // Well-formed body with random content, now and then damaged
   task automatic build_random_body();
      int unsigned size;
      int unsigned cut;
      repeat ($urandom_range(0, 4)) begin
         size = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         put_size_line(size);
         repeat (size) put_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 5) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            put_crlf();
         end
      end
      put_size_line(0);
      repeat ($urandom_range(0, 2)) begin
         put_text("X-T:");
         repeat ($urandom_range(0, 24)) put_byte(8'($urandom_range(32, 126)));
         put_crlf();
      end
      // a CR before CR LF is not an empty line
      if ($urandom_range(0, 5) == 0) begin
         put_byte(cbd_pkg::CH_CR);
         put_crlf();
      end
      put_crlf();
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
         0: body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
         1: begin
            cut = $urandom_range(1, body_q.size());
            while (body_q.size() > cut) void'(body_q.pop_back());
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_byte(logic [7:0] b, logic sob);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.byte_in       <= b;
      req_bus.start_of_body <= sob;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Send the body; restart on its first byte mostly, rarely mid-stream
   task automatic send_body();
      calm = ($urandom_range(0, 4) == 0);
      foreach (body_q[i])
         send_byte(body_q[i], (i == 0 && $urandom_range(0, 9) != 0) ||
                              $urandom_range(0, 199) == 0);
      body_q.delete();
   endtask

   // Send the body as it stands, restarting on its first byte only
   task automatic send_exact();
      foreach (body_q[i]) send_byte(body_q[i], i == 0);
      body_q.delete();
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [16:0] limit);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {cbd_pkg::REG_MAX_LINE_LENGTH, 2'b00};
      csr_pwdata  <= 32'(limit);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic run_phase(logic [16:0] limit, int unsigned quota);
      int unsigned sent;
      sent = 0;
      csr_write(limit);
      while (sent < quota) begin
         build_random_body();
         sent += body_q.size();
         send_body();
      end
      drain();
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (250) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.byte_in       = '0;
      req_bus.start_of_body = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, at the reset line limit: payload 00 and FF, then completion
      put_text("2"); put_crlf(); put_byte(8'h00); put_byte(8'hFF); put_crlf();
      put_text("0"); put_crlf(); put_crlf();
      send_exact();
      // hex prefix reads as size zero, then the closing empty line
      put_text("0x"); put_crlf(); put_crlf();
      send_exact();
      // sign first is malformed, and the error sticks
      put_text("-1"); put_crlf(); put_text("7");
      send_exact();
      // ninth significant digit overflows
      put_text("100000000");
      send_exact();
      drain();

      // Random phases over several line limits, extremes included
      long_hold = 1'b1;
      run_phase(17'd65536, 350);
      run_phase(17'd1, 40);
      run_phase(17'd8, 200);
      run_phase(17'd20, 250);
      run_phase(17'($urandom_range(2, 40)), 250);
      run_phase(17'd65536, 400);

      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cbd_pkg.sv
rtl/cbd_if.sv
rtl/cbd_csr.sv
rtl/cbd_engine.sv
rtl/chunked_body_decoder_core.sv
test/chunked_decode_checker.sv
test/testbench.sv
